// ===== rtl/core/pde_pkg.sv =====
// Shared widths, types and state codes of the pairwise distance engine.
package pde_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned SQ_W    = 2 * COORD_W;
  localparam int unsigned RAD_W   = SQ_W + 2;
  localparam int unsigned ROOT_W  = RAD_W / 2;
  localparam int unsigned REM_W   = ROOT_W + 1;
  localparam int unsigned POINT_W = 3 * COORD_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_OVF
  } pde_state_e;

  // Bookkeeping that travels alongside each distance through the pipeline.
  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic             overflow;
    logic             last;
  } pde_tag_t;

endpackage

// ===== rtl/core/pde_if.sv =====
// Valid/ready channel interfaces for the point words and the result words.
interface pde_in_if;
  logic                            valid;
  logic                            ready;
  logic                            first;
  logic signed [pde_pkg::COORD_W-1:0] coord_x;
  logic signed [pde_pkg::COORD_W-1:0] coord_y;
  logic signed [pde_pkg::COORD_W-1:0] coord_z;

  modport source (output valid, first, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, first, coord_x, coord_y, coord_z, output ready);
endinterface

interface pde_out_if;
  logic                         valid;
  logic                         ready;
  logic [pde_pkg::IDX_W-1:0]    row_index;
  logic [pde_pkg::IDX_W-1:0]    col_index;
  logic [pde_pkg::ROOT_W-1:0]   distance;
  logic                         overflow;
  logic                         last;

  modport source (output valid, row_index, col_index, distance, overflow, last,
                  input ready);
  modport sink (input valid, row_index, col_index, distance, overflow, last,
                output ready);
endinterface

// ===== rtl/core/pairwise_distance_engine_core.sv =====
// Top level of the pairwise distance engine: point store, read sequencer, distance pipeline.
//
// Each accepted point word is written into the point store and then compared
// with every earlier point of the current set in stored order, one store read
// per cycle while the output is not stalled, through the single read port of
// the point store. A new point is accepted only once every pair of the last
// one has been launched. The first point of a set has nothing to compare
// against, and a dropped point launches only its overflow word. Every pair
// flows through a 38-stage pipeline (store read, absolute differences,
// squares, sum, 33 square-root stages, output register) and leaves as one
// result word with row_index = new point, col_index = earlier point and the
// floored Q17.16 Euclidean distance; last marks the final word of a point.
// A point arriving when MAX_POINTS are already stored (and first is low) is
// dropped and yields one word with overflow and last set and all other fields
// zero. Setting first restarts the set at index zero. The whole pipeline
// stalls as one when the output word is not taken, so no result is lost.
module pairwise_distance_engine_core #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pde_in_if.sink      in_i,
  pde_out_if.source   res_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  // Sign-extended difference of two coordinates, returned as a magnitude.
  function automatic logic [pde_pkg::COORD_W-1:0] abs_diff(
    input logic [pde_pkg::COORD_W-1:0] a,
    input logic [pde_pkg::COORD_W-1:0] b
  );
    logic [pde_pkg::COORD_W:0] d;
    logic [pde_pkg::COORD_W:0] m;
    d = {a[pde_pkg::COORD_W-1], a} - {b[pde_pkg::COORD_W-1], b};
    m = d[pde_pkg::COORD_W] ? (~d + 1'b1) : d;
    return m[pde_pkg::COORD_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Sequencer state.
  // ---------------------------------------------------------------------
  pde_pkg::pde_state_e state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       row_q, row_d;
  logic [AW-1:0]       col_q, col_d;
  logic [pde_pkg::POINT_W-1:0] pt_q;

  logic                accept;
  logic [CW-1:0]       eff_count;
  logic                full;
  logic                advance;
  logic                issue;
  logic                issue_ovf;
  logic                issue_last;
  logic                wr_en;

  logic                out_valid_q;

  assign in_i.ready = (state_q == pde_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign eff_count  = in_i.first ? '0 : count_q;
  assign full       = (eff_count >= CW'(MAX_POINTS));

  // The pipeline moves only when the output register is free or being drained.
  assign advance = !out_valid_q || res_o.ready;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    row_d      = row_q;
    col_d      = col_q;
    issue      = 1'b0;
    issue_ovf  = 1'b0;
    issue_last = 1'b0;
    wr_en      = 1'b0;
    unique case (state_q)
      pde_pkg::ST_IDLE: begin
        if (accept) begin
          if (full) begin
            state_d = pde_pkg::ST_OVF;
          end else begin
            wr_en   = 1'b1;
            count_d = eff_count + CW'(1);
            row_d   = eff_count[AW-1:0];
            col_d   = '0;
            // The first point of a set has nothing to compare against.
            if (eff_count != '0) begin
              state_d = pde_pkg::ST_ISSUE;
            end
          end
        end
      end
      pde_pkg::ST_ISSUE: begin
        if (advance) begin
          issue      = 1'b1;
          issue_last = (col_q == row_q - AW'(1));
          col_d      = col_q + AW'(1);
          if (issue_last) begin
            state_d = pde_pkg::ST_IDLE;
          end
        end
      end
      pde_pkg::ST_OVF: begin
        if (advance) begin
          issue      = 1'b1;
          issue_ovf  = 1'b1;
          issue_last = 1'b1;
          state_d    = pde_pkg::ST_IDLE;
        end
      end
      default: state_d = pde_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pde_pkg::ST_IDLE;
      count_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  // The new point is held here while its pairs are launched.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pt_q <= {in_i.coord_x, in_i.coord_y, in_i.coord_z};
    end
  end

  // ---------------------------------------------------------------------
  // Point store: one write port used on accept, one registered read port
  // used while pairs are launched. The two never overlap in time, and a
  // point only ever reads entries written before it.
  // ---------------------------------------------------------------------
  logic [pde_pkg::POINT_W-1:0] store_mem [MAX_POINTS];
  logic [pde_pkg::POINT_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[eff_count[AW-1:0]] <= {in_i.coord_x, in_i.coord_y, in_i.coord_z};
    end
    if (issue) begin
      rd_q <= store_mem[col_q];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: store read in flight; the new point and tag ride along.
  // ---------------------------------------------------------------------
  logic                        s1_v_q;
  pde_pkg::pde_tag_t           s1_tag_q;
  logic [pde_pkg::POINT_W-1:0] s1_pt_q;
  pde_pkg::pde_tag_t           issue_tag;

  always_comb begin
    issue_tag           = '0;
    issue_tag.overflow  = issue_ovf;
    issue_tag.last      = issue_last;
    if (!issue_ovf) begin
      issue_tag.row_index = pde_pkg::IDX_W'(row_q);
      issue_tag.col_index = pde_pkg::IDX_W'(col_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (advance) begin
      s1_v_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_tag_q <= issue_tag;
      s1_pt_q  <= pt_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: absolute coordinate differences.
  // ---------------------------------------------------------------------
  localparam int unsigned CWD = pde_pkg::COORD_W;

  logic                  s2_v_q;
  pde_pkg::pde_tag_t     s2_tag_q;
  logic [CWD-1:0]        s2_ux_q, s2_uy_q, s2_uz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (advance) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_tag_q <= s1_tag_q;
      s2_ux_q  <= abs_diff(s1_pt_q[3*CWD-1 -: CWD], rd_q[3*CWD-1 -: CWD]);
      s2_uy_q  <= abs_diff(s1_pt_q[2*CWD-1 -: CWD], rd_q[2*CWD-1 -: CWD]);
      s2_uz_q  <= abs_diff(s1_pt_q[CWD-1 -: CWD],   rd_q[CWD-1 -: CWD]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: one 32 x 32 multiplier per axis.
  // ---------------------------------------------------------------------
  logic                       s3_v_q;
  pde_pkg::pde_tag_t          s3_tag_q;
  logic [pde_pkg::SQ_W-1:0]   s3_sx_q, s3_sy_q, s3_sz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (advance) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_tag_q <= s2_tag_q;
      s3_sx_q  <= s2_ux_q * s2_ux_q;
      s3_sy_q  <= s2_uy_q * s2_uy_q;
      s3_sz_q  <= s2_uz_q * s2_uz_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: exact sum of the squares in 66 bits.
  // ---------------------------------------------------------------------
  logic                        s4_v_q;
  pde_pkg::pde_tag_t           s4_tag_q;
  logic [pde_pkg::RAD_W-1:0]   s4_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (advance) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s4_tag_q <= s3_tag_q;
      s4_sum_q <= pde_pkg::RAD_W'(s3_sx_q) + pde_pkg::RAD_W'(s3_sy_q)
                + pde_pkg::RAD_W'(s3_sz_q);
    end
  end

  // ---------------------------------------------------------------------
  // Square root pipeline and output register.
  // ---------------------------------------------------------------------
  logic                        sq_valid;
  pde_pkg::pde_tag_t           sq_tag;
  logic [pde_pkg::ROOT_W-1:0]  sq_root;

  pde_isqrt_pipe u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .valid_i    (s4_v_q),
    .tag_i      (s4_tag_q),
    .radicand_i (s4_sum_q),
    .valid_o    (sq_valid),
    .tag_o      (sq_tag),
    .root_o     (sq_root)
  );

  pde_pkg::pde_tag_t           out_tag_q;
  logic [pde_pkg::ROOT_W-1:0]  out_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= sq_valid;
    end
  end

  // A dropped point carries no meaningful distance, so it is forced to zero.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_tag_q  <= sq_tag;
      out_dist_q <= sq_tag.overflow ? '0 : sq_root;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.row_index = out_tag_q.row_index;
  assign res_o.col_index = out_tag_q.col_index;
  assign res_o.distance  = out_dist_q;
  assign res_o.overflow  = out_tag_q.overflow;
  assign res_o.last      = out_tag_q.last;

endmodule

// ===== rtl/core/pde_isqrt_pipe.sv =====
// Pipelined floored integer square root, one root bit resolved per stage.
module pde_isqrt_pipe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  pde_pkg::pde_tag_t           tag_i,
  input  logic [pde_pkg::RAD_W-1:0]   radicand_i,
  output logic                        valid_o,
  output pde_pkg::pde_tag_t           tag_o,
  output logic [pde_pkg::ROOT_W-1:0]  root_o
);

  localparam int unsigned NSTG = pde_pkg::ROOT_W;

  logic                        v_q    [NSTG];
  pde_pkg::pde_tag_t           tag_q  [NSTG];
  logic [pde_pkg::RAD_W-1:0]   x_q    [NSTG];
  logic [pde_pkg::REM_W-1:0]   rem_q  [NSTG];
  logic [pde_pkg::ROOT_W-1:0]  root_q [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic                          v_in;
    pde_pkg::pde_tag_t             tag_in;
    logic [pde_pkg::RAD_W-1:0]     x_in;
    logic [pde_pkg::REM_W-1:0]     rem_in;
    logic [pde_pkg::ROOT_W-1:0]    root_in;
    logic [pde_pkg::REM_W+1:0]     r2;
    logic [pde_pkg::REM_W+1:0]     trial;
    logic [pde_pkg::REM_W+1:0]     diff;
    logic                          take;

    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign tag_in  = tag_i;
      assign x_in    = radicand_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_body
      assign v_in    = v_q[k-1];
      assign tag_in  = tag_q[k-1];
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // Bring down the next two radicand bits and try the root bit as one.
    always_comb begin
      r2    = {rem_in, x_in[pde_pkg::RAD_W-1 -: 2]};
      trial = {1'b0, root_in, 2'b01};
      diff  = r2 - trial;
      take  = (r2 >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[k]  <= tag_in;
        x_q[k]    <= {x_in[pde_pkg::RAD_W-3:0], 2'b00};
        rem_q[k]  <= take ? diff[pde_pkg::REM_W-1:0] : r2[pde_pkg::REM_W-1:0];
        root_q[k] <= {root_in[pde_pkg::ROOT_W-2:0], take};
      end
    end
  end

  assign valid_o = v_q[NSTG-1];
  assign tag_o   = tag_q[NSTG-1];
  assign root_o  = root_q[NSTG-1];

endmodule

// ===== rtl/core/pde_checker.sv =====
// Port-level checks of the pairwise distance engine and their bind to the top level.
module pde_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        res_valid_i,
  input  logic                        res_ready_i,
  input  logic [pde_pkg::IDX_W-1:0]   row_index_i,
  input  logic [pde_pkg::IDX_W-1:0]   col_index_i,
  input  logic [pde_pkg::ROOT_W-1:0]  distance_i,
  input  logic                        overflow_i,
  input  logic                        last_i
);

  // A stalled result word keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(row_index_i)
      && $stable(col_index_i) && $stable(distance_i) && $stable(overflow_i)
      && $stable(last_i))
    else $error("result word changed while stalled");

  // A dropped point gives a single, otherwise empty word.
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && overflow_i |-> last_i && distance_i == '0
      && row_index_i == '0 && col_index_i == '0)
    else $error("overflow word malformed");

  // Only the lower triangle is produced.
  a_tri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !overflow_i |-> col_index_i < row_index_i)
    else $error("pair outside the lower triangle");

  // The closing word of a point pairs it with its immediate predecessor.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !overflow_i && last_i |-> col_index_i + 1'b1 == row_index_i)
    else $error("last word does not close the row");

endmodule

bind pairwise_distance_engine_core pde_checker u_pde_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .row_index_i (res_o.row_index),
  .col_index_i (res_o.col_index),
  .distance_i  (res_o.distance),
  .overflow_i  (res_o.overflow),
  .last_i      (res_o.last)
);
